// ===== sv/pdd_pkg.sv =====
// Shared types and constants for the PID differential drive block.
// Holds the payload and config structs, the microcode control word and its field codes.
// No dependencies.
package pdd_pkg;

  typedef struct packed {
    logic signed [15:0] line_error;
    logic [15:0]        interval;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] left_drive;
    logic signed [15:0] right_drive;
  } drive_t;

  typedef struct packed {
    logic [15:0] prop_gain;
    logic [15:0] integ_gain;
    logic [15:0] deriv_gain;
    logic [14:0] base_speed;
    logic [14:0] integ_limit;
  } cfg_t;

  // Config register indexes
  localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [2:0] REG_DERIV_GAIN  = 3'd2;
  localparam logic [2:0] REG_BASE_SPEED  = 3'd3;
  localparam logic [2:0] REG_INTEG_LIMIT = 3'd4;

  localparam logic [15:0] RST_PROP_GAIN   = 16'd819;
  localparam logic [15:0] RST_INTEG_GAIN  = 16'd33;
  localparam logic [15:0] RST_DERIV_GAIN  = 16'd410;
  localparam logic [14:0] RST_BASE_SPEED  = 15'd17859;
  localparam logic [14:0] RST_INTEG_LIMIT = 15'd13107;

  // Multiplier operand A select
  localparam logic [2:0] A_ERR    = 3'd0;
  localparam logic [2:0] A_DIFF   = 3'd1;
  localparam logic [2:0] A_SUM_LO = 3'd2;
  localparam logic [2:0] A_SUM_HI = 3'd3;
  localparam logic [2:0] A_X_LO   = 3'd4;
  localparam logic [2:0] A_X_HI   = 3'd5;

  // Multiplier operand B select
  localparam logic [1:0] B_DT = 2'd0;
  localparam logic [1:0] B_IG = 2'd1;
  localparam logic [1:0] B_DG = 2'd2;
  localparam logic [1:0] B_PG = 2'd3;

  // Accumulator operation
  localparam logic [1:0] ACC_HOLD  = 2'd0;
  localparam logic [1:0] ACC_LOAD  = 2'd1;
  localparam logic [1:0] ACC_ADDHI = 2'd2;

  // Writeback action
  localparam logic [2:0] WB_NONE = 3'd0;
  localparam logic [2:0] WB_SUM  = 3'd1;
  localparam logic [2:0] WB_X    = 3'd2;
  localparam logic [2:0] WB_IFIN = 3'd3;
  localparam logic [2:0] WB_PFIN = 3'd4;
  localparam logic [2:0] WB_DFIN = 3'd5;
  localparam logic [2:0] WB_OUT  = 3'd6;

  // Sequencing
  localparam logic [1:0] SEQ_NEXT     = 2'd0;
  localparam logic [1:0] SEQ_WAIT_IN  = 2'd1;
  localparam logic [1:0] SEQ_WAIT_OUT = 2'd2;
  localparam logic [1:0] SEQ_RESTART  = 2'd3;

  typedef struct packed {
    logic [2:0] a_sel;
    logic [1:0] b_sel;
    logic [1:0] acc_op;
    logic [2:0] wb;
    logic [1:0] seq;
  } ctrl_t;

endpackage

// ===== sv/pid_differential_drive.sv =====
// PID line-follower drive controller, top level.
// drive_valid rises once the output step finds the output register free; the next
// sample is taken only after that. The single shared 25x18 multiplier steps through
// an 11-step microprogram per sample.
// Reset (synchronous, rst high): gains return to defaults, integral sum and previous
// error clear to zero, no drive request pending.
module pid_differential_drive import pdd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        sample_valid,
  output logic        sample_ready,
  input  sample_t     sample,
  output logic        drive_valid,
  input  logic        drive_ready,
  output drive_t      drive,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t  cfg;
  ctrl_t ctrl;
  logic  out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain   <= RST_PROP_GAIN;
      cfg.integ_gain  <= RST_INTEG_GAIN;
      cfg.deriv_gain  <= RST_DERIV_GAIN;
      cfg.base_speed  <= RST_BASE_SPEED;
      cfg.integ_limit <= RST_INTEG_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PROP_GAIN:   cfg.prop_gain   <= cfg_data;
        REG_INTEG_GAIN:  cfg.integ_gain  <= cfg_data;
        REG_DERIV_GAIN:  cfg.deriv_gain  <= cfg_data;
        REG_BASE_SPEED:  cfg.base_speed  <= cfg_data[14:0];
        REG_INTEG_LIMIT: cfg.integ_limit <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  assign sample_ready = (ctrl.seq == SEQ_WAIT_IN);

  pdd_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .out_free     (out_free),
    .ctrl         (ctrl)
  );

  pdd_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .cfg         (cfg),
    .load_sample (sample_valid && sample_ready),
    .sample      (sample),
    .out_free    (out_free),
    .drive_valid (drive_valid),
    .drive_ready (drive_ready),
    .drive       (drive)
  );

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && sample_ready) |=> !sample_ready)
    else $error("sample_ready still high after a sample was taken");

  a_load_from_out_step: assert property (@(posedge clk) disable iff (rst)
    $rose(drive_valid) |-> $past(ctrl.wb == WB_OUT))
    else $error("drive_valid rose outside the output step");

  a_result_arrives: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && sample_ready) |-> ##11 drive_valid)
    else $error("no drive request pending 11 cycles after a sample");
`endif

endmodule

// ===== sv/pdd_seq.sv =====
// Microcode sequencer: step counter and control store for the PID datapath.
// Depends on pdd_pkg for the control word layout and codes.
module pdd_seq import pdd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  sample_valid,
  input  logic  out_free,
  output ctrl_t ctrl
);

  localparam logic [3:0] STEP_START = 4'd0;

  logic [3:0] step;
  logic [3:0] step_next;

  function automatic ctrl_t ucode(input logic [3:0] addr);
    ctrl_t c;
    c = '{a_sel: A_ERR, b_sel: B_DT, acc_op: ACC_HOLD, wb: WB_NONE, seq: SEQ_NEXT};
    case (addr)
      4'd0:  c.seq = SEQ_WAIT_IN;
      4'd1:  begin c.a_sel = A_ERR;    c.b_sel = B_DT; end
      4'd2:  begin c.a_sel = A_DIFF;   c.b_sel = B_DT; c.wb = WB_SUM; end
      4'd3:  begin c.a_sel = A_SUM_LO; c.b_sel = B_IG; c.wb = WB_X; end
      4'd4:  begin c.a_sel = A_SUM_HI; c.b_sel = B_IG; c.acc_op = ACC_LOAD; end
      4'd5:  begin c.a_sel = A_X_LO;   c.b_sel = B_DG; c.acc_op = ACC_ADDHI; end
      4'd6:  begin
        c.a_sel = A_X_HI; c.b_sel = B_DG; c.acc_op = ACC_LOAD; c.wb = WB_IFIN;
      end
      4'd7:  begin c.a_sel = A_ERR;    c.b_sel = B_PG; c.acc_op = ACC_ADDHI; end
      4'd8:  c.wb = WB_PFIN;
      4'd9:  c.wb = WB_DFIN;
      4'd10: begin c.wb = WB_OUT; c.seq = SEQ_WAIT_OUT; end
      default: c.seq = SEQ_RESTART;
    endcase
    return c;
  endfunction

  assign ctrl = ucode(step);

  always_comb begin
    step_next = step;
    unique case (ctrl.seq)
      SEQ_NEXT:     step_next = step + 4'd1;
      SEQ_WAIT_IN:  if (sample_valid) step_next = step + 4'd1;
      SEQ_WAIT_OUT: if (out_free) step_next = STEP_START;
      SEQ_RESTART:  step_next = STEP_START;
      default:      step_next = STEP_START;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_START;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== sv/pdd_datapath.sv =====
// PID datapath: one shared 25x18 multiplier, accumulator, term registers and output register.
// Driven by the control word from pdd_seq; depends on pdd_pkg.
module pdd_datapath import pdd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  ctrl_t   ctrl,
  input  cfg_t    cfg,
  input  logic    load_sample,
  input  sample_t sample,
  output logic    out_free,
  output logic    drive_valid,
  input  logic    drive_ready,
  output drive_t  drive
);

  localparam logic signed [39:0] SUM_MAX = {1'b0, {39{1'b1}}};
  localparam logic signed [39:0] SUM_MIN = {1'b1, {39{1'b0}}};
  localparam logic signed [24:0] DRV_MAX = 25'sd32767;
  localparam logic signed [24:0] DRV_MIN = -25'sd32767;

  logic signed [15:0] err;
  logic [15:0]        dt;
  logic signed [39:0] error_sum;
  logic signed [15:0] prev_error;
  logic signed [32:0] xprod;
  logic signed [42:0] prod;
  logic signed [56:0] acc;
  logic signed [15:0] i_term;
  logic signed [20:0] p_term;
  logic signed [22:0] d_term;

  logic signed [16:0] diff;
  logic signed [24:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [40:0] sum_wide;
  logic signed [39:0] sum_sat;
  logic signed [56:0] acc_round;
  logic signed [28:0] acc_q;
  logic signed [28:0] lim_pos;
  logic signed [28:0] lim_neg;
  logic signed [42:0] p_round;
  logic signed [24:0] corr;
  logic signed [24:0] left_raw;
  logic signed [24:0] right_raw;
  logic signed [15:0] left_sat;
  logic signed [15:0] right_sat;

  assign diff = {err[15], err} - {prev_error[15], prev_error};

  always_comb begin
    case (ctrl.a_sel)
      A_ERR:    mul_a = {{9{err[15]}}, err};
      A_DIFF:   mul_a = {{8{diff[16]}}, diff};
      A_SUM_LO: mul_a = {9'b0, error_sum[15:0]};
      A_SUM_HI: mul_a = {error_sum[39], error_sum[39:16]};
      A_X_LO:   mul_a = {9'b0, xprod[15:0]};
      A_X_HI:   mul_a = {{8{xprod[32]}}, xprod[32:16]};
      default:  mul_a = '0;
    endcase
    case (ctrl.b_sel)
      B_DT:    mul_b = {2'b0, dt};
      B_IG:    mul_b = {2'b0, cfg.integ_gain};
      B_DG:    mul_b = {2'b0, cfg.deriv_gain};
      B_PG:    mul_b = {2'b0, cfg.prop_gain};
      default: mul_b = '0;
    endcase
  end

  // Saturating integral update; product here is error * interval
  always_comb begin
    sum_wide = {error_sum[39], error_sum} + {{8{prod[32]}}, prod[32:0]};
    if (sum_wide[40] != sum_wide[39]) begin
      sum_sat = sum_wide[40] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_wide[39:0];
    end
  end

  // acc holds either gain*sum or gain*diff*dt, both at 2^-43; round to Q1.15
  assign acc_round = acc + {29'b0, 1'b1, 27'b0};
  assign acc_q     = acc_round[56:28];
  assign lim_pos   = {14'b0, cfg.integ_limit};
  assign lim_neg   = -lim_pos;
  assign p_round   = prod + 43'sd2048;

  always_comb begin
    corr = {{4{p_term[20]}}, p_term} + {{9{i_term[15]}}, i_term}
         + {{2{d_term[22]}}, d_term};
    left_raw  = {10'b0, cfg.base_speed} + corr;
    right_raw = {10'b0, cfg.base_speed} - corr;
    if (left_raw > DRV_MAX) left_sat = DRV_MAX[15:0];
    else if (left_raw < DRV_MIN) left_sat = DRV_MIN[15:0];
    else left_sat = left_raw[15:0];
    if (right_raw > DRV_MAX) right_sat = DRV_MAX[15:0];
    else if (right_raw < DRV_MIN) right_sat = DRV_MIN[15:0];
    else right_sat = right_raw[15:0];
  end

  assign out_free = !drive_valid || drive_ready;

  always_ff @(posedge clk) begin
    if (load_sample) begin
      err <= sample.line_error;
      dt  <= sample.interval;
    end
    prod <= mul_a * mul_b;
    case (ctrl.acc_op)
      ACC_LOAD:  acc <= {{14{prod[42]}}, prod};
      ACC_ADDHI: acc <= acc + {prod[40:0], 16'b0};
      default:   acc <= acc;
    endcase
    case (ctrl.wb)
      WB_X:    xprod <= prod[32:0];
      WB_IFIN: begin
        if (acc_q > lim_pos || acc_q < lim_neg) i_term <= '0;
        else i_term <= acc_q[15:0];
      end
      WB_PFIN: p_term <= p_round[32:12];
      WB_DFIN: d_term <= acc_q[22:0];
      WB_OUT:  if (out_free) drive <= '{left_drive: left_sat, right_drive: right_sat};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum   <= '0;
      prev_error  <= '0;
      drive_valid <= 1'b0;
    end else begin
      if (ctrl.wb == WB_SUM) error_sum <= sum_sat;
      if (ctrl.wb == WB_X) prev_error <= err;
      if (ctrl.wb == WB_OUT && out_free) begin
        drive_valid <= 1'b1;
      end else if (drive_ready) begin
        drive_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== test/pdd_drive_checker.sv =====
// Drive checker for the PID differential drive block: tracks register writes, predicts each
// drive request from accepted samples and compares it with what the block hands out.
// Depends on pdd_pkg for the sample, drive and register types and the register indexes.
module pdd_drive_checker import pdd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        sample_valid,
  input  logic        sample_ready,
  input  sample_t     sample,
  input  logic        drive_valid,
  input  logic        drive_ready,
  input  drive_t      drive,
  output int          fail_count,
  output int          pending
);

  localparam longint SUM_TOP    = (longint'(1) <<< 39) - 1;
  localparam longint SUM_BOTTOM = -(longint'(1) <<< 39);
  localparam longint SPEED_TOP  = 32767;

  cfg_t   gains;
  longint integral_sum;
  longint last_error;
  drive_t expected_drives[$];
  int     mismatches = 0;

  // round to nearest, ties upward, then drop n fraction bits
  function automatic longint to_q15(input longint x, input int unsigned n);
    return (x + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic logic signed [15:0] limit_speed(input longint v);
    if (v > SPEED_TOP)
      return 16'(SPEED_TOP);
    if (v < -SPEED_TOP)
      return 16'(-SPEED_TOP);
    return 16'(v);
  endfunction

  function automatic drive_t predict_drive(input sample_t s);
    longint err, dt, iterm, pterm, dterm, corr, lim, base;
    drive_t d;
    err = longint'(s.line_error);
    dt  = longint'(s.interval);
    integral_sum = integral_sum + err * dt;
    if (integral_sum > SUM_TOP)
      integral_sum = SUM_TOP;
    if (integral_sum < SUM_BOTTOM)
      integral_sum = SUM_BOTTOM;
    iterm = to_q15(longint'(gains.integ_gain) * integral_sum, 28);
    lim = longint'(gains.integ_limit);
    // integral term beyond the cutoff is dropped for this step only
    if (iterm > lim || iterm < -lim)
      iterm = 0;
    pterm = to_q15(longint'(gains.prop_gain) * err, 12);
    dterm = to_q15(longint'(gains.deriv_gain) * (err - last_error) * dt, 28);
    last_error = err;
    corr = pterm + iterm + dterm;
    base = longint'(gains.base_speed);
    d.left_drive  = limit_speed(base + corr);
    d.right_drive = limit_speed(base - corr);
    return d;
  endfunction

  always @(posedge clk) begin
    drive_t want;
    if (rst) begin
      gains.prop_gain   = RST_PROP_GAIN;
      gains.integ_gain  = RST_INTEG_GAIN;
      gains.deriv_gain  = RST_DERIV_GAIN;
      gains.base_speed  = RST_BASE_SPEED;
      gains.integ_limit = RST_INTEG_LIMIT;
      integral_sum = 0;
      last_error   = 0;
      expected_drives.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PROP_GAIN:   gains.prop_gain   = cfg_data;
          REG_INTEG_GAIN:  gains.integ_gain  = cfg_data;
          REG_DERIV_GAIN:  gains.deriv_gain  = cfg_data;
          REG_BASE_SPEED:  gains.base_speed  = cfg_data[14:0];
          REG_INTEG_LIMIT: gains.integ_limit = cfg_data[14:0];
          default: ;
        endcase
      end
      // retire before queuing, so a same-edge sample never answers an older request
      if (drive_valid && drive_ready) begin
        if (expected_drives.size() == 0) begin
          $error("unexpected drive request: left_drive %0d, right_drive %0d",
                 drive.left_drive, drive.right_drive);
          mismatches++;
        end else begin
          want = expected_drives.pop_front();
          if (drive.left_drive !== want.left_drive) begin
            $error("left_drive: expected %0d, got %0d", want.left_drive, drive.left_drive);
            mismatches++;
          end
          if (drive.right_drive !== want.right_drive) begin
            $error("right_drive: expected %0d, got %0d", want.right_drive, drive.right_drive);
            mismatches++;
          end
        end
      end
      if (sample_valid && sample_ready)
        expected_drives.push_back(predict_drive(sample));
    end
    pending    <= expected_drives.size();
    fail_count <= mismatches;
  end

endmodule

// ===== test/pid_differential_drive_tb.sv =====
// Testbench top for pid_differential_drive: clock, reset, register settings and sample
// stimulus with random idling and a long drive hold-off; pdd_drive_checker does the checking.
// Depends on pdd_pkg, pid_differential_drive and pdd_drive_checker.
module pid_differential_drive_tb;
  import pdd_pkg::*;

  localparam int HOLD_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst;
  logic        sample_valid;
  logic        sample_ready;
  sample_t     sample;
  logic        drive_valid;
  logic        drive_ready;
  drive_t      drive;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  int          fail_count;
  int          pending;

  bit steady    = 1'b0;  // no idling on either side
  bit hold_sink = 1'b0;  // ask the drive side to hold off
  int sent      = 0;
  int settings  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pid_differential_drive uut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
    .drive_valid(drive_valid), .drive_ready(drive_ready), .drive(drive),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pdd_drive_checker drive_chk (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
    .drive_valid(drive_valid), .drive_ready(drive_ready), .drive(drive),
    .fail_count(fail_count), .pending(pending)
  );

  // drive side: random stalls, plus one long hold-off on request
  initial begin
    drive_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_sink) begin
        drive_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_sink = 1'b0;
      end
      drive_ready <= steady || ($urandom_range(99) >= 30);
    end
  end

  task automatic offer(input logic signed [15:0] err, input logic [15:0] dt);
    while (!steady && $urandom_range(99) < 30) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= {err, dt};
    do @(posedge clk); while (!sample_ready);
    sent++;
  endtask

  // sender pause until every drive request has been taken
  task automatic wait_idle();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic load_gains(input cfg_t g);
    cfg_we <= 1'b1;
    cfg_index <= REG_PROP_GAIN;
    cfg_data  <= g.prop_gain;
    @(posedge clk);
    cfg_index <= REG_INTEG_GAIN;
    cfg_data  <= g.integ_gain;
    @(posedge clk);
    cfg_index <= REG_DERIV_GAIN;
    cfg_data  <= g.deriv_gain;
    @(posedge clk);
    // top bit of the 15-bit registers is don't-care
    cfg_index <= REG_BASE_SPEED;
    cfg_data  <= {1'($urandom_range(1)), g.base_speed};
    @(posedge clk);
    cfg_index <= REG_INTEG_LIMIT;
    cfg_data  <= {1'($urandom_range(1)), g.integ_limit};
    @(posedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  function automatic cfg_t random_gains();
    cfg_t g;
    g.prop_gain   = 16'($urandom());
    g.integ_gain  = 16'($urandom());
    g.deriv_gain  = 16'($urandom());
    g.base_speed  = 15'($urandom());
    g.integ_limit = 15'($urandom());
    return g;
  endfunction

  // mostly line-following sized samples, some full-range noise, some zero intervals
  task automatic random_sample();
    int pick;
    int mag;
    pick = $urandom_range(9);
    mag  = $urandom_range(4000);
    if (pick < 6)
      offer($urandom_range(1) ? 16'(mag) : 16'(-mag), 16'($urandom_range(2000, 30)));
    else if (pick < 9)
      offer(16'($urandom()), $urandom_range(3) == 0 ? 16'hFFFF : 16'($urandom()));
    else
      offer(16'($urandom()), 16'd0);
  endtask

  // long same-sign run that drives the integral sum into its rail
  task automatic push_integral(input int count, input bit downward);
    int mag;
    logic [15:0] dt;
    for (int k = 0; k < count; k++) begin
      mag = downward ? $urandom_range(32768, 30000) : $urandom_range(32767, 30000);
      dt  = ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom_range(65535, 60000));
      offer(downward ? 16'(-mag) : 16'(mag), dt);
    end
  endtask

  initial begin
    cfg_t g;
    rst          <= 1'b1;
    sample_valid <= 1'b0;
    sample       <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_PROP_GAIN;
    cfg_data     <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset gains: field extremes, most negative error, zero intervals
    offer(16'sd0, 16'd0);
    offer(16'sd32767, 16'hFFFF);
    offer(-16'sd32768, 16'hFFFF);
    offer(-16'sd32767, 16'hFFFF);
    offer(16'sd1, 16'd0);
    offer(-16'sd1, 16'd1);
    offer(16'sd32767, 16'd0);
    offer(-16'sd32768, 16'd1);
    offer(16'sd0, 16'hFFFF);
    offer(16'sd12000, 16'd66);
    offer(-16'sd12000, 16'd66);
    offer(16'sd0, 16'd66);
    wait_idle();

    // every gain at its top: integral cutoff and drive clamping
    load_gains('{prop_gain: 16'hFFFF, integ_gain: 16'hFFFF, deriv_gain: 16'hFFFF,
                 base_speed: 15'h7FFF, integ_limit: 15'h7FFF});
    offer(16'sd100, 16'd10);
    offer(-16'sd100, 16'd10);
    offer(-16'sd32768, 16'hFFFF);
    offer(16'sd32767, 16'hFFFF);
    offer(16'sd0, 16'd0);
    offer(16'sd5, 16'd1);
    wait_idle();

    load_gains('0);
    offer(16'sd32767, 16'hFFFF);
    offer(-16'sd32768, 16'hFFFF);
    offer(16'sd0, 16'd0);
    offer(16'sd1, 16'd1);
    wait_idle();

    g = random_gains();
    g.base_speed  = 15'h7FFF;
    g.integ_limit = '0;
    load_gains(g);
    offer(16'sd32767, 16'd100);
    offer(-16'sd32768, 16'd100);
    offer(16'sd0, 16'd0);
    wait_idle();

    load_gains(random_gains());
    repeat (200) random_sample();
    wait_idle();

    // no idling anywhere while the sum climbs to its upper rail
    load_gains(random_gains());
    steady = 1'b1;
    push_integral(320, 1'b0);
    steady = 1'b0;
    wait_idle();

    g = random_gains();
    g.integ_gain  = 16'd1;
    g.integ_limit = 15'h7FFF;
    load_gains(g);
    repeat (60) random_sample();
    wait_idle();

    // drive side holds off while samples keep coming; sum swings to the lower rail
    load_gains(random_gains());
    hold_sink = 1'b1;
    push_integral(600, 1'b1);
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      g = random_gains();
      if (ph == 1)
        g.integ_limit = '0;
      if (ph == 2) begin
        g.prop_gain  = 16'hFFFF;
        g.base_speed = 15'h7FFF;
      end
      load_gains(g);
      repeat (80) random_sample();
      wait_idle();
    end

    // catch stray drive requests
    repeat (30) @(posedge clk);
    $display("%0d samples over %0d register settings; integral driven to both rails,",
             sent, settings);
    $display("drive side held off for %0d cycles under load", HOLD_CYCLES);
    if (fail_count == 0)
      $display("pid_differential_drive_tb: done, clean");
    else
      $display("pid_differential_drive_tb: done, errors");
    $finish;
  end

  initial begin
    #3000000;
    $display("pid_differential_drive_tb: done, errors");
    $finish;
  end

endmodule
